// ===== design/bresenham_line_color_gradient_unit_defines.svh =====
// assertion macros for the line rasteriser checker
// depends on nothing; taken in by the checker file
`ifndef BRESENHAM_LINE_COLOR_GRADIENT_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_COLOR_GRADIENT_UNIT_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define BLCG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BLCG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/blcg_pkg.sv =====
// shared types and constants of the line rasteriser
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps

package blcg_pkg;

	localparam int CoordBits = 6;
	localparam int ColorBits = 8;
	localparam int Channels = 3;
	localparam int ColorWidth = Channels * ColorBits;
	localparam int DivCountBits = $clog2(ColorBits);

	localparam logic [ColorWidth-1:0] StartColorReset = 24'h00FF00;
	localparam logic [ColorWidth-1:0] EndColorReset = 24'hFF0000;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic [CoordBits-1:0] dist_t;
	typedef logic [ColorBits-1:0] chan_t;

	typedef enum logic {
		RegStartColor = 1'b0,
		RegEndColor = 1'b1
	} reg_index_t;

	// strobes from the sequencer to the datapath and the colour lanes
	typedef struct packed {
		logic accept;
		logic order;
		logic div_step;
		logic div_fix;
		logic emit;
	} ctrl_t;

	// flags from the datapath back to the sequencer
	typedef struct packed {
		logic div_more;
		logic last_cell;
		logic out_free;
	} status_t;

endpackage

// ===== design/bresenham_line_color_gradient_unit.sv =====
// top level of the line rasteriser with colour gradient
// depends on blcg_pkg, blcg_sequencer, blcg_datapath, blcg_color_lane
`timescale 1ns / 1ps

// channel    direction  handshake             payload
// in         request    in_valid / in_stall   first_x first_y second_x second_y
// out        result     out_valid / out_stall pixel_x pixel_y red green blue last_pixel
// config     write      wr_en                 wr_index wr_data
//
// a line covers n cells (n = major extent + 1, at most 64); the time from one accept to the next is set
// by the eight-step bit-serial slope divide, run in all three colour lanes at once, and by the walk,
// which emits one cell per cycle while the output is not stalled
// in_stall is high from the cycle after an accept until the sequencer is back at its wait step
// out_stall freezes the output register while it holds a valid cell and then holds the walk on its current cell
// reset clears the step counter and the output valid and loads the colour registers with their reset colours

module bresenham_line_color_gradient_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic                                wr_index,
	input  logic [blcg_pkg::ColorWidth-1:0]     wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  blcg_pkg::coord_t                    first_x,
	input  blcg_pkg::coord_t                    first_y,
	input  blcg_pkg::coord_t                    second_x,
	input  blcg_pkg::coord_t                    second_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output blcg_pkg::coord_t                    pixel_x,
	output blcg_pkg::coord_t                    pixel_y,
	output blcg_pkg::chan_t                     red,
	output blcg_pkg::chan_t                     green,
	output blcg_pkg::chan_t                     blue,
	output logic                                last_pixel
);
	import blcg_pkg::*;

	// colour registers, red in the top byte
	logic [ColorWidth-1:0] start_color_q;
	logic [ColorWidth-1:0] end_color_q;

	ctrl_t   ctrl;
	status_t status;
	dist_t   dmaj;
	chan_t   lane_chan [Channels];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_color_q <= StartColorReset;
			end_color_q <= EndColorReset;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				RegStartColor: start_color_q <= wr_data;
				RegEndColor:   end_color_q <= wr_data;
				default:       start_color_q <= start_color_q;
			endcase
		end
	end

	// control: wait, order endpoints, divide, fix sign, emit cells, return
	blcg_sequencer u_sequencer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_stall (in_stall),
		.ctrl     (ctrl)
	);

	// axis swap, endpoint ordering and the error-term walk
	blcg_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.status     (status),
		.first_x    (first_x),
		.first_y    (first_y),
		.second_x   (second_x),
		.second_y   (second_y),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel),
		.dmaj       (dmaj)
	);

	// one lane per channel; lane 0 is red
	for (genvar c = 0; c < Channels; c++) begin : g_lane
		blcg_color_lane u_lane (
			.clk        (clk),
			.ctrl       (ctrl),
			.divisor    (dmaj),
			.start_chan (start_color_q[(Channels-1-c)*ColorBits +: ColorBits]),
			.end_chan   (end_color_q[(Channels-1-c)*ColorBits +: ColorBits]),
			.chan       (lane_chan[c])
		);
	end

	assign red = lane_chan[0];
	assign green = lane_chan[1];
	assign blue = lane_chan[2];

endmodule

// ===== design/blcg_sequencer.sv =====
// microcoded sequencer: step counter, control store and jump logic
// depends on blcg_pkg
`timescale 1ns / 1ps

module blcg_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  blcg_pkg::status_t status,
	output logic              in_stall,
	output blcg_pkg::ctrl_t   ctrl
);
	import blcg_pkg::*;

	typedef enum logic [2:0] {
		OpWait,
		OpOrder,
		OpDivStep,
		OpDivFix,
		OpEmit,
		OpJump
	} op_t;

	typedef enum logic [2:0] {
		CondNever,
		CondAlways,
		CondNoRequest,
		CondDivMore,
		CondEmitMore
	} cond_t;

	localparam int StepBits = 3;
	typedef logic [StepBits-1:0] step_t;

	localparam step_t StepWait = step_t'(0);
	localparam step_t StepOrder = step_t'(1);
	localparam step_t StepDivide = step_t'(2);
	localparam step_t StepFix = step_t'(3);
	localparam step_t StepEmit = step_t'(4);
	localparam step_t StepReturn = step_t'(5);

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	// control store
	function automatic uword_t ucode(step_t pc);
		uword_t w;
		case (pc)
			StepWait:   w = '{op: OpWait,    cond: CondNoRequest, target: StepWait};
			StepOrder:  w = '{op: OpOrder,   cond: CondNever,     target: StepWait};
			StepDivide: w = '{op: OpDivStep, cond: CondDivMore,   target: StepDivide};
			StepFix:    w = '{op: OpDivFix,  cond: CondNever,     target: StepWait};
			StepEmit:   w = '{op: OpEmit,    cond: CondEmitMore,  target: StepEmit};
			StepReturn: w = '{op: OpJump,    cond: CondAlways,    target: StepWait};
			default:    w = '{op: OpJump,    cond: CondAlways,    target: StepWait};
		endcase
		return w;
	endfunction

	step_t  pc_q;
	step_t  pc_n;
	uword_t word;
	logic   taken;

	always_comb begin
		word = ucode(pc_q);
		in_stall = (word.op != OpWait);
		ctrl.accept = (word.op == OpWait) && in_valid;
		ctrl.order = (word.op == OpOrder);
		ctrl.div_step = (word.op == OpDivStep);
		ctrl.div_fix = (word.op == OpDivFix);
		ctrl.emit = (word.op == OpEmit) && status.out_free;
		case (word.cond)
			CondNever:     taken = 1'b0;
			CondAlways:    taken = 1'b1;
			CondNoRequest: taken = !in_valid;
			CondDivMore:   taken = status.div_more;
			CondEmitMore:  taken = !(ctrl.emit && status.last_cell);
			default:       taken = 1'b0;
		endcase
		pc_n = taken ? word.target : pc_q + step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= StepWait;
		end else begin
			pc_q <= pc_n;
		end
	end

endmodule

// ===== design/blcg_datapath.sv =====
// geometry datapath: endpoint ordering, bresenham walk and cell output register
// depends on blcg_pkg; driven by blcg_sequencer strobes
`timescale 1ns / 1ps

module blcg_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  blcg_pkg::ctrl_t   ctrl,
	output blcg_pkg::status_t status,
	input  blcg_pkg::coord_t  first_x,
	input  blcg_pkg::coord_t  first_y,
	input  blcg_pkg::coord_t  second_x,
	input  blcg_pkg::coord_t  second_y,
	input  logic              out_stall,
	output logic              out_valid,
	output blcg_pkg::coord_t  pixel_x,
	output blcg_pkg::coord_t  pixel_y,
	output logic              last_pixel,
	output blcg_pkg::dist_t   dmaj
);
	import blcg_pkg::*;

	localparam int ErrBits = CoordBits + 3;

	function automatic dist_t abs_diff(coord_t a, coord_t b);
		logic signed [CoordBits:0] d;
		d = {a[CoordBits-1], a} - {b[CoordBits-1], b};
		return d[CoordBits] ? dist_t'(-d) : dist_t'(d);
	endfunction

	coord_t x0_q, y0_q, x1_q, y1_q;
	coord_t major_q, minor_q;
	dist_t  dmaj_q, remain_q;
	logic [CoordBits:0] derr_q;
	logic   swapped_q, step_up_q;
	logic signed [ErrBits-1:0] err_q;
	logic [DivCountBits-1:0] div_cnt_q;
	logic   out_valid_q, last_q;
	coord_t pixel_x_q, pixel_y_q;

	dist_t  adx, ady, dmin_abs, dmaj_n;
	logic   swap_n, flip, up_n;
	coord_t pa0, pb0, pa1, pb1, maj_lo, maj_hi, min_lo, min_hi;
	logic signed [ErrBits-1:0] err_add, dmaj_ext, two_dmaj;
	logic   minor_move;

	always_comb begin
		adx = abs_diff(x0_q, x1_q);
		ady = abs_diff(y0_q, y1_q);
		// ties keep x as the major axis
		swap_n = adx < ady;
		pa0 = swap_n ? y0_q : x0_q;
		pb0 = swap_n ? x0_q : y0_q;
		pa1 = swap_n ? y1_q : x1_q;
		pb1 = swap_n ? x1_q : y1_q;
		flip = pa0 > pa1;
		maj_lo = flip ? pa1 : pa0;
		maj_hi = flip ? pa0 : pa1;
		min_lo = flip ? pb1 : pb0;
		min_hi = flip ? pb0 : pb1;
		dmaj_n = dist_t'(maj_hi - maj_lo);
		dmin_abs = abs_diff(min_hi, min_lo);
		up_n = min_hi > min_lo;

		dmaj_ext = $signed({{(ErrBits-CoordBits){1'b0}}, dmaj_q});
		two_dmaj = $signed({{(ErrBits-CoordBits-1){1'b0}}, dmaj_q, 1'b0});
		err_add = err_q + $signed({{(ErrBits-CoordBits-1){1'b0}}, derr_q});
		minor_move = err_add > dmaj_ext;

		status.div_more = (div_cnt_q != '0);
		status.last_cell = (remain_q == '0);
		status.out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			x0_q <= first_x;
			y0_q <= first_y;
			x1_q <= second_x;
			y1_q <= second_y;
		end
		if (ctrl.order) begin
			swapped_q <= swap_n;
			major_q <= maj_lo;
			minor_q <= min_lo;
			dmaj_q <= dmaj_n;
			remain_q <= dmaj_n;
			derr_q <= {dmin_abs, 1'b0};
			step_up_q <= up_n;
			err_q <= '0;
			div_cnt_q <= DivCountBits'(ColorBits - 1);
		end else if (ctrl.div_step) begin
			div_cnt_q <= div_cnt_q - DivCountBits'(1);
		end else if (ctrl.emit) begin
			pixel_x_q <= swapped_q ? minor_q : major_q;
			pixel_y_q <= swapped_q ? major_q : minor_q;
			last_q <= (remain_q == '0);
			major_q <= major_q + coord_t'(1);
			remain_q <= remain_q - dist_t'(1);
			if (minor_move) begin
				minor_q <= step_up_q ? minor_q + coord_t'(1) : minor_q - coord_t'(1);
				err_q <= err_add - two_dmaj;
			end else begin
				err_q <= err_add;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x = pixel_x_q;
	assign pixel_y = pixel_y_q;
	assign last_pixel = last_q;
	assign dmaj = dmaj_q;

endmodule

// ===== design/blcg_color_lane.sv =====
// one colour channel: bit-serial divide of the slope, then incremental interpolation
// depends on blcg_pkg; driven by blcg_sequencer strobes
`timescale 1ns / 1ps

module blcg_color_lane (
	input  logic            clk,
	input  blcg_pkg::ctrl_t ctrl,
	input  blcg_pkg::dist_t divisor,
	input  blcg_pkg::chan_t start_chan,
	input  blcg_pkg::chan_t end_chan,
	output blcg_pkg::chan_t chan
);
	import blcg_pkg::*;

	localparam int AccBits = ColorBits + 2;

	chan_t quo_q, chan_q;
	dist_t rem_q, rd_q;
	logic  neg_q;
	logic signed [AccBits-1:0] qd_q, acc_q;

	logic signed [ColorBits:0] diff;
	logic  neg_n;
	chan_t mag_n;
	logic [CoordBits:0] trial, sum;
	logic  fits, wrap;
	logic signed [AccBits-1:0] qmag;

	always_comb begin
		diff = $signed({1'b0, end_chan}) - $signed({1'b0, start_chan});
		neg_n = diff[ColorBits];
		mag_n = neg_n ? ColorBits'(-diff) : ColorBits'(diff);
		trial = {rem_q, quo_q[ColorBits-1]};
		fits = trial >= {1'b0, divisor};
		sum = {1'b0, rem_q} + {1'b0, rd_q};
		wrap = sum >= {1'b0, divisor};
		qmag = $signed({2'b00, quo_q});
	end

	always_ff @(posedge clk) begin
		if (ctrl.order) begin
			quo_q <= mag_n;
			neg_q <= neg_n;
			rem_q <= '0;
			acc_q <= $signed({2'b00, start_chan});
		end else if (ctrl.div_step) begin
			quo_q <= {quo_q[ColorBits-2:0], fits};
			rem_q <= fits ? CoordBits'(trial - {1'b0, divisor}) : trial[CoordBits-1:0];
		end else if (ctrl.div_fix) begin
			// floor the quotient: a negative slope rounds down, a positive one passes unchanged
			rem_q <= '0;
			if (neg_q && rem_q != '0) begin
				qd_q <= AccBits'(-qmag - 1);
				rd_q <= divisor - rem_q;
			end else if (neg_q) begin
				qd_q <= -qmag;
				rd_q <= '0;
			end else begin
				qd_q <= qmag;
				rd_q <= rem_q;
			end
		end else if (ctrl.emit) begin
			chan_q <= acc_q[ColorBits-1:0];
			rem_q <= wrap ? CoordBits'(sum - {1'b0, divisor}) : sum[CoordBits-1:0];
			acc_q <= acc_q + qd_q + $signed({{(AccBits-1){1'b0}}, wrap});
		end
	end

	assign chan = chan_q;

endmodule

// ===== design/blcg_checker.sv =====
// port-level checks of the line rasteriser and their bind to the top level
// depends on blcg_pkg and bresenham_line_color_gradient_unit_defines.svh
`timescale 1ns / 1ps
`include "bresenham_line_color_gradient_unit_defines.svh"

module blcg_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input blcg_pkg::coord_t pixel_x,
	input blcg_pkg::coord_t pixel_y,
	input blcg_pkg::chan_t  red,
	input blcg_pkg::chan_t  green,
	input blcg_pkg::chan_t  blue,
	input logic             last_pixel
);
	import blcg_pkg::*;

	// a stalled cell stays put
	`BLCG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(red) && $stable(green) && $stable(blue) && $stable(last_pixel), "stalled cell changed")

	// only one line in flight
	`BLCG_ASSERT_NEXT(a_one_line, clk, arst_n, in_valid && !in_stall, in_stall, "request taken while a line is in flight")

	// a cell that is not the last means the walk is still busy
	`BLCG_ASSERT_SAME(a_busy_mid_line, clk, arst_n, out_valid && !last_pixel, in_stall, "request port open in the middle of a line")

endmodule

bind bresenham_line_color_gradient_unit blcg_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pixel_x    (pixel_x),
	.pixel_y    (pixel_y),
	.red        (red),
	.green      (green),
	.blue       (blue),
	.last_pixel (last_pixel)
);

// ===== dv/tb.sv =====
// self-checking bench for the line rasteriser with colour gradient
// depends on blcg_pkg and bresenham_line_color_gradient_unit
`timescale 1ns / 1ps

module tb;
	import blcg_pkg::*;

	localparam int CoordMin = -(1 << (CoordBits - 1));
	localparam int CoordMax = (1 << (CoordBits - 1)) - 1;
	localparam int MaxIdle = 18;
	localparam int WatchLimit = 4000;
	localparam int TailCycles = 120;
	localparam int RandPhases = 8;
	localparam int LinesPerPhase = 40;

	typedef enum {StepLine, StepWrite, StepDrain} step_kind_t;

	// one entry of the stimulus script
	typedef struct {
		step_kind_t kind;
		coord_t x0, y0, x1, y1;
		reg_index_t idx;
		logic [ColorWidth-1:0] data;
		int gap;
	} step_t;

	// one predicted cell
	typedef struct {
		int x, y;
		int chan[Channels];
		int last;
	} cell_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic wr_index = 1'b0;
	logic [ColorWidth-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	coord_t first_x = '0;
	coord_t first_y = '0;
	coord_t second_x = '0;
	coord_t second_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	coord_t pixel_x, pixel_y;
	chan_t red, green, blue;
	logic last_pixel;

	step_t script[$];
	cell_t cells_due[$];
	logic [ColorWidth-1:0] grad_start, grad_end;
	int errors = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	int calm_left = 0;
	step_t head;
	logic nxt_valid, nxt_wr;
	cell_t got_cell;

	bresenham_line_color_gradient_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_x(first_x),
		.first_y(first_y),
		.second_x(second_x),
		.second_y(second_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.red(red),
		.green(green),
		.blue(blue),
		.last_pixel(last_pixel)
	);

	always #1 clk = ~clk;

	// walks one segment with the current gradient and queues every cell it covers
	task automatic rasterise_line(input coord_t x0, input coord_t y0, input coord_t x1,
			input coord_t y1);
		int a0, b0, a1, b1, tmp, dmaj, derr, err, minor, mstep, dx, dy, k, c, bc, ec;
		bit swap;
		cell_t pix;
		a0 = x0;
		b0 = y0;
		a1 = x1;
		b1 = y1;
		dx = a0 > a1 ? a0 - a1 : a1 - a0;
		dy = b0 > b1 ? b0 - b1 : b1 - b0;
		// equal extents keep x as the major axis
		swap = dx < dy;
		if (swap) begin
			tmp = a0; a0 = b0; b0 = tmp;
			tmp = a1; a1 = b1; b1 = tmp;
		end
		// walk always runs towards the higher major coordinate
		if (a0 > a1) begin
			tmp = a0; a0 = a1; a1 = tmp;
			tmp = b0; b0 = b1; b1 = tmp;
		end
		dmaj = a1 - a0;
		derr = 2 * (b1 > b0 ? b1 - b0 : b0 - b1);
		mstep = b1 > b0 ? 1 : -1;
		err = 0;
		minor = b0;
		for (k = 0; k <= dmaj; k++) begin
			pix.x = swap ? minor : a0 + k;
			pix.y = swap ? a0 + k : minor;
			for (c = 0; c < Channels; c++) begin
				bc = grad_start[ColorWidth-1-ColorBits*c -: ColorBits];
				ec = grad_end[ColorWidth-1-ColorBits*c -: ColorBits];
				// a single-cell line takes the start colour as it is
				pix.chan[c] = dmaj == 0 ? bc : (bc * (dmaj - k) + ec * k) / dmaj;
			end
			pix.last = k == dmaj;
			cells_due.insert(cells_due.size(), pix);
			err += derr;
			if (err > dmaj) begin
				minor += mstep;
				err -= 2 * dmaj;
			end
		end
	endtask

	task automatic check_field(input string what, input integer want, input integer got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// receiver hold-off per result, with occasional runs of no stall at all
	function automatic int draw_hold();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		return $urandom_range(0, MaxIdle);
	endfunction

	function automatic int clamp_coord(input int v);
		return v < CoordMin ? CoordMin : (v > CoordMax ? CoordMax : v);
	endfunction

	task automatic queue_line(input int x0, input int y0, input int x1, input int y1,
			input bit calm);
		step_t s;
		s.kind = StepLine;
		s.x0 = coord_t'(x0);
		s.y0 = coord_t'(y0);
		s.x1 = coord_t'(x1);
		s.y1 = coord_t'(y1);
		s.idx = RegStartColor;
		s.data = '0;
		s.gap = calm ? 0 : $urandom_range(0, MaxIdle);
		script.insert(script.size(), s);
	endtask

	task automatic queue_write(input reg_index_t idx, input logic [ColorWidth-1:0] data);
		step_t s;
		s.kind = StepWrite;
		s.x0 = '0;
		s.y0 = '0;
		s.x1 = '0;
		s.y1 = '0;
		s.idx = idx;
		s.data = data;
		s.gap = 0;
		script.insert(script.size(), s);
	endtask

	task automatic queue_drain();
		step_t s;
		s.kind = StepDrain;
		s.x0 = '0;
		s.y0 = '0;
		s.x1 = '0;
		s.y1 = '0;
		s.idx = RegStartColor;
		s.data = '0;
		s.gap = 0;
		script.insert(script.size(), s);
	endtask

	// mix of arbitrary, short, axis-aligned, diagonal and single-cell segments
	task automatic queue_random_line(input bit calm);
		int x0, y0, x1, y1, shape, sx, sy, reach;
		x0 = $urandom_range(0, 63) + CoordMin;
		y0 = $urandom_range(0, 63) + CoordMin;
		x1 = $urandom_range(0, 63) + CoordMin;
		y1 = $urandom_range(0, 63) + CoordMin;
		shape = $urandom_range(0, 9);
		if (shape inside {5, 6}) begin
			x1 = clamp_coord(x0 + $urandom_range(0, 8) - 4);
			y1 = clamp_coord(y0 + $urandom_range(0, 8) - 4);
		end else if (shape == 7) begin
			if ($urandom_range(0, 1))
				y1 = y0;
			else
				x1 = x0;
		end else if (shape == 8) begin
			sx = $urandom_range(0, 1) ? 1 : -1;
			sy = $urandom_range(0, 1) ? 1 : -1;
			reach = sx > 0 ? CoordMax - x0 : x0 - CoordMin;
			reach = (sy > 0 ? CoordMax - y0 : y0 - CoordMin) < reach ?
				(sy > 0 ? CoordMax - y0 : y0 - CoordMin) : reach;
			reach = $urandom_range(0, reach);
			x1 = x0 + sx * reach;
			y1 = y0 + sy * reach;
		end else if (shape == 9) begin
			x1 = x0;
			y1 = y0;
		end
		queue_line(x0, y0, x1, y1, calm);
	endtask

	// request driver: walks the script, predicting each line as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			first_x <= '0;
			first_y <= '0;
			second_x <= '0;
			second_y <= '0;
			wr_en <= 1'b0;
			wr_index <= RegStartColor;
			wr_data <= '0;
			grad_start = StartColorReset;
			grad_end = EndColorReset;
		end else begin
			// a request still stalled keeps its payload and stays up
			nxt_valid = in_valid && in_stall;
			nxt_wr = 1'b0;
			if (in_valid && !in_stall)
				rasterise_line(first_x, first_y, second_x, second_y);
			if (!nxt_valid && script.size() > 0) begin
				head = script[0];
				case (head.kind)
				StepLine: begin
					if (head.gap > 0) begin
						script[0].gap = head.gap - 1;
					end else begin
						first_x <= head.x0;
						first_y <= head.y0;
						second_x <= head.x1;
						second_y <= head.y1;
						nxt_valid = 1'b1;
						void'(script.pop_front());
					end
				end
				StepWrite: begin
					// registers only change once the block has gone quiet
					if (cells_due.size() == 0 && !in_valid && !in_stall) begin
						nxt_wr = 1'b1;
						wr_index <= head.idx;
						wr_data <= head.data;
						if (head.idx == RegStartColor)
							grad_start = head.data;
						else
							grad_end = head.data;
						void'(script.pop_front());
					end
				end
				default: begin
					// hold back until every predicted cell has come out
					if (cells_due.size() == 0)
						void'(script.pop_front());
				end
				endcase
			end
			in_valid <= nxt_valid;
			wr_en <= nxt_wr;
		end
	end

	// result monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cells_due.size() == 0) begin
					errors++;
					$display("%0t ns: cell expected none, got (%0d,%0d)", $time,
						pixel_x, pixel_y);
				end else begin
					got_cell = cells_due.pop_front();
					check_field("pixel_x", got_cell.x, pixel_x);
					check_field("pixel_y", got_cell.y, pixel_y);
					check_field("red", got_cell.chan[0], red);
					check_field("green", got_cell.chan[1], green);
					check_field("blue", got_cell.chan[2], blue);
					check_field("last_pixel", got_cell.last, last_pixel);
				end
				hold_left = draw_hold();
			end else if (out_valid && hold_left > 0) begin
				hold_left--;
			end
			out_stall <= hold_left > 0;
		end
	end

	// watchdog: cycles without a request taken or a register write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		// directed part, reset gradient first
		queue_line(CoordMin, CoordMin, CoordMin, CoordMin, 1'b0);
		queue_line(CoordMax, CoordMax, CoordMax, CoordMax, 1'b0);
		queue_line(CoordMin, 0, CoordMax, 0, 1'b0);
		queue_line(CoordMax, -5, CoordMin, -5, 1'b0);
		queue_line(0, CoordMin, 0, CoordMax, 1'b0);
		queue_line(7, CoordMax, 7, CoordMin, 1'b0);
		queue_line(CoordMin, CoordMin, CoordMax, CoordMax, 1'b0);
		queue_line(CoordMax, CoordMin, CoordMin, CoordMax, 1'b0);
		queue_drain();
		queue_line(CoordMin, CoordMax, CoordMax, CoordMin, 1'b0);
		queue_line(-20, -30, 25, 10, 1'b0);
		queue_line(3, CoordMin, -4, CoordMax, 1'b0);
		queue_line(10, 10, 13, 11, 1'b0);
		// black to white
		queue_write(RegStartColor, '0);
		queue_write(RegEndColor, '1);
		queue_line(CoordMin, 5, CoordMax, 6, 1'b0);
		queue_line(5, CoordMin, 6, CoordMax, 1'b0);
		queue_line(0, 0, 1, 0, 1'b0);
		queue_line(-1, -1, -1, -1, 1'b0);
		// white to black
		queue_write(RegStartColor, '1);
		queue_write(RegEndColor, '0);
		queue_line(CoordMax, 0, CoordMin, -1, 1'b0);
		queue_line(-9, 20, -9, -12, 1'b0);
		queue_line(0, 0, 5, 5, 1'b0);
		queue_line(CoordMax, CoordMax, CoordMin, CoordMin, 1'b0);

		// random phases, each under its own gradient; two of them with no sender gaps
		for (int p = 0; p < RandPhases; p++) begin
			case (p)
			1: begin
				queue_write(RegStartColor, '1);
				queue_write(RegEndColor, '1);
			end
			2: begin
				queue_write(RegStartColor, '0);
				queue_write(RegEndColor, '0);
			end
			default: begin
				queue_write(RegStartColor, ColorWidth'($urandom));
				queue_write(RegEndColor, ColorWidth'($urandom));
			end
			endcase
			for (int n = 0; n < LinesPerPhase; n++) begin
				if (n == LinesPerPhase / 2)
					queue_drain();
				queue_random_line(p == 3 || p == 6);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// sampled on the falling edge so the clocked blocks have settled
		while (!(script.size() == 0 && !in_valid && cells_due.size() == 0) &&
				idle_cycles < WatchLimit)
			@(negedge clk);
		if (idle_cycles >= WatchLimit) begin
			$display("FAILURE");
		end else begin
			repeat (TailCycles) @(negedge clk);
			if (cells_due.size() != 0) begin
				errors++;
				$display("%0t ns: cells expected 0 outstanding, got %0d", $time,
					cells_due.size());
			end
			if (errors == 0)
				$display("SUCCESS");
			else
				$display("FAILURE");
		end
		$finish;
	end

endmodule
